// File: design/pecsv_pkg.sv
// ----------------------------------------------------------------------------
// PE checksum validator package
// Shared codes, header constants and the header-position decode record.
// ----------------------------------------------------------------------------
package pecsv_pkg;

    localparam logic [15:0] DOS_MAGIC      = 16'h5A4D;
    localparam logic [15:0] NT_SIG_LOW     = 16'h4550;
    localparam logic [15:0] NT_SIG_HIGH    = 16'h0000;
    localparam logic [15:0] OPT_MAGIC32    = 16'h010B;
    localparam logic [15:0] LARGE_ADDR_BIT = 16'h0020;
    localparam logic [15:0] LOW16          = 16'hFFFF;
    localparam int          LARGE_ADDR_POS = 5;

    // Word indexes inside the DOS header that carry the header offset
    localparam logic [32:0] POS_OFF_LOW  = 33'd30;
    localparam logic [32:0] POS_OFF_HIGH = 33'd31;
    localparam logic [31:0] MIN_OFFSET   = 32'd64;

    // Word offsets from the NT header word
    localparam logic [32:0] NT_SIG_HI_OFS = 33'd1;
    localparam logic [32:0] NT_CHARS_OFS  = 33'd11;
    localparam logic [32:0] NT_OPT_OFS    = 33'd12;
    localparam logic [32:0] NT_CS_LO_OFS  = 33'd44;
    localparam logic [32:0] NT_CS_HI_OFS  = 33'd45;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_DOS     = 3'd1,
        ST_BAD_NT      = 3'd2,
        ST_BAD_OPT     = 3'd3,
        ST_SUM_MISMATCH = 3'd4,
        ST_TRUNCATED   = 3'd5
    } t_status;

    typedef enum logic [0:0] {
        CFG_FILE_SIZE = 1'b0,
        CFG_RAW_FLAG  = 1'b1
    } t_cfg_reg;

    // Which header field the current word is, plus whether the checksum
    // field has been fully passed
    typedef struct packed {
        logic sig_lo;
        logic sig_hi;
        logic chars;
        logic opt;
        logic cs_lo;
        logic cs_hi;
        logic complete;
    } t_hits;

endpackage

// File: design/pecsv_locate.sv
// ----------------------------------------------------------------------------
// PE checksum validator: header field locator
// Compares the word position against the NT header layout.
// ----------------------------------------------------------------------------
module pecsv_locate
    import pecsv_pkg::*;
#(
    parameter int POSITION_BITS = 31
) (
    input  logic [POSITION_BITS-1:0] i_pos,
    input  logic [31:0]              i_hdr_off,
    output t_hits                    o_hits
);

    localparam int          PAD     = 33 - POSITION_BITS;
    localparam logic [32:0] POS_MAX = (33'd1 << POSITION_BITS) - 33'd1;

    logic [32:0] pos_w;
    logic [32:0] nt;
    logic [32:0] cs_hi;
    logic        usable;
    logic        live;
    logic        in_hdr;

    always_comb begin
        pos_w  = {{PAD{1'b0}}, i_pos};
        nt     = {2'b00, i_hdr_off[31:1]};
        cs_hi  = nt + NT_CS_HI_OFS;
        usable = !i_hdr_off[0] && (i_hdr_off >= MIN_OFFSET);
        live   = pos_w != POS_MAX;
        in_hdr = live && (pos_w > POS_OFF_HIGH) && usable;

        o_hits.sig_lo   = in_hdr && (pos_w == nt);
        o_hits.sig_hi   = in_hdr && (pos_w == nt + NT_SIG_HI_OFS);
        o_hits.chars    = in_hdr && (pos_w == nt + NT_CHARS_OFS);
        o_hits.opt      = in_hdr && (pos_w == nt + NT_OPT_OFS);
        o_hits.cs_lo    = in_hdr && (pos_w == nt + NT_CS_LO_OFS);
        o_hits.cs_hi    = in_hdr && (pos_w == cs_hi);
        o_hits.complete = (pos_w > POS_OFF_HIGH) && usable
                          && (cs_hi < POS_MAX) && (pos_w >= cs_hi);
    end

endmodule

// File: design/pe_image_checksum_validator.sv
// ----------------------------------------------------------------------------
// PE image checksum validator
// Streams a 32-bit PE image as 16-bit words, checks its headers and
// recomputes the optional-header checksum.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+---------------------------
//  in        | sink      | i_in_valid / o_in_ready   | i_image_word, i_final_word
//  out       | source    | o_out_valid / i_out_ready | o_check_status,
//            |           |                           | o_large_address_flag,
//            |           |                           | o_computed_sum, o_stored_sum
//  cfg       | sink      | i_cfg_we (no wait)        | i_cfg_index, i_cfg_data
//
//  One word transaction is taken every cycle unless a final word is held back
//  by a full output. Each word sits in the input register, then one adder pass
//  and the header position compares update the state; a final word's result
//  goes from the input register to the output register when that is free.
//  Reset (synchronous, active low) clears the configuration, the per-image
//  state and both valid flags.
//  A waiting result stalls only a final word: ordinary words keep flowing
//  while the output register holds its transaction.
// ----------------------------------------------------------------------------
module pe_image_checksum_validator
    import pecsv_pkg::*;
#(
    parameter int POSITION_BITS = 31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_image_word,
    input  logic        i_final_word,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_check_status,
    output logic        o_large_address_flag,
    output logic [31:0] o_computed_sum,
    output logic [31:0] o_stored_sum,

    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    // Configuration
    logic [31:0] r_file_size;
    logic        r_raw_flag;

    // Input register
    logic        r_in_valid;
    logic [15:0] r_word;
    logic        r_fin;

    // Per-image state
    logic [POSITION_BITS-1:0] r_pos,     n_pos;
    logic [31:0]              r_hdr_off, n_hdr_off;
    logic [16:0]              r_sum,     n_sum;
    logic [15:0]              r_chars,   n_chars;
    logic [31:0]              r_cs,      n_cs;
    t_status                  r_err,     n_err;
    logic [15:0]              r_sig_lo,  n_sig_lo;

    // Output register
    logic        r_out_valid;
    t_status     r_status, n_status;
    logic        r_large;
    logic [31:0] r_computed, n_computed;
    logic [31:0] r_stored;

    t_hits       hits;
    logic        adv;
    logic        out_free;
    logic        live;
    logic        usable_new;
    t_status     step_err;
    logic [16:0] fold1;
    logic [16:0] fold2;
    logic [15:0] addend;

    pecsv_locate #(
        .POSITION_BITS (POSITION_BITS)
    ) u_locate (
        .i_pos     (r_pos),
        .i_hdr_off (r_hdr_off),
        .o_hits    (hits)
    );

    // Process the held word unless it is final and the output is still full
    assign out_free   = !r_out_valid || i_out_ready;
    assign adv        = r_in_valid && (!r_fin || out_free);
    assign o_in_ready = !r_in_valid || adv;

    always_comb begin
        live = r_pos != POS_MAX;

        // Header offset capture from DOS header words 30 and 31
        n_hdr_off = r_hdr_off;
        if (live && ({{(33-POSITION_BITS){1'b0}}, r_pos} == POS_OFF_LOW)) begin
            n_hdr_off[15:0] = r_word;
        end
        if (live && ({{(33-POSITION_BITS){1'b0}}, r_pos} == POS_OFF_HIGH)) begin
            n_hdr_off[31:16] = r_word;
        end
        usable_new = !n_hdr_off[0] && (n_hdr_off >= MIN_OFFSET);

        // Only one check can apply to a given word position
        step_err = ST_OK;
        if (live && (r_pos == '0) && (r_word != DOS_MAGIC)) begin
            step_err = ST_BAD_DOS;
        end else if (live && ({{(33-POSITION_BITS){1'b0}}, r_pos} == POS_OFF_HIGH)
                     && !usable_new) begin
            step_err = ST_TRUNCATED;
        end else if (hits.sig_hi && ((r_sig_lo != NT_SIG_LOW) || (r_word != NT_SIG_HIGH))) begin
            step_err = ST_BAD_NT;
        end else if (hits.opt && (r_word != OPT_MAGIC32)) begin
            step_err = ST_BAD_OPT;
        end
        n_err = (r_err != ST_OK) ? r_err : step_err;

        n_sig_lo = hits.sig_lo ? r_word : r_sig_lo;
        n_chars  = hits.chars  ? r_word : r_chars;
        n_cs     = r_cs;
        if (hits.cs_lo) begin
            n_cs[15:0] = r_word;
        end
        if (hits.cs_hi) begin
            n_cs[31:16] = r_word;
        end

        // End-around carry sum; fold twice at the stored checksum and skip it
        fold1  = {1'b0, r_sum[15:0]} + {16'd0, r_sum[16]};
        fold2  = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
        addend = (hits.chars && !r_raw_flag) ? (r_word & (LOW16 & ~LARGE_ADDR_BIT)) : r_word;
        if (hits.cs_lo) begin
            n_sum = fold2;
        end else if (hits.cs_hi) begin
            n_sum = r_sum;
        end else begin
            n_sum = {1'b0, r_sum[15:0]} + {1'b0, addend} + {16'd0, r_sum[16]};
        end

        n_pos = live ? r_pos + POS_ONE : r_pos;

        n_computed = {16'd0, n_sum[15:0]} + r_file_size + {31'd0, n_sum[16]};
        if (n_err != ST_OK) begin
            n_status = n_err;
        end else if (!hits.complete) begin
            n_status = ST_TRUNCATED;
        end else if (n_computed != n_cs) begin
            n_status = ST_SUM_MISMATCH;
        end else begin
            n_status = ST_OK;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_size <= '0;
            r_raw_flag  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_FILE_SIZE: r_file_size <= i_cfg_data;
                CFG_RAW_FLAG:  r_raw_flag  <= i_cfg_data[0];
            endcase
        end
    end

    // Input register: take a new transaction whenever the held one moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_word <= i_image_word;
            r_fin  <= i_final_word;
        end
    end

    // Per-image state: advance on every word, clear after the final one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (adv && r_fin)) begin
            r_pos     <= '0;
            r_hdr_off <= '0;
            r_sum     <= '0;
            r_chars   <= '0;
            r_cs      <= '0;
            r_err     <= ST_OK;
            r_sig_lo  <= '0;
        end else if (adv) begin
            r_pos     <= n_pos;
            r_hdr_off <= n_hdr_off;
            r_sum     <= n_sum;
            r_chars   <= n_chars;
            r_cs      <= n_cs;
            r_err     <= n_err;
            r_sig_lo  <= n_sig_lo;
        end
    end

    // Output register: load on a final word, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_fin) begin
            r_status   <= n_status;
            r_large    <= n_chars[LARGE_ADDR_POS];
            r_computed <= n_computed;
            r_stored   <= n_cs;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_check_status       = r_status;
    assign o_large_address_flag = r_large;
    assign o_computed_sum       = r_computed;
    assign o_stored_sum         = r_stored;

`ifndef SYNTH
    a_clear_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_fin |=> (r_pos == '0) && (r_err == ST_OK) && (r_sum == '0))
        else $error("state not cleared after final word");

    a_result_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(adv && r_fin))
        else $error("result raised without a final word");

    a_pos_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !r_fin && (r_pos == POS_MAX) |=> r_pos == POS_MAX)
        else $error("word position wrapped");

    a_fold_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !r_fin && hits.cs_lo |=> !r_sum[16])
        else $error("folded sum carries a bit above 16");

    a_ok_sums_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_status == ST_OK) |-> r_computed == r_stored)
        else $error("ok status with differing sums");
`endif

endmodule
